### hdl/s2c_pkg.sv
// Shared constants, codes and types of the sphere to cube face mapper.
`default_nettype none
package s2c_pkg;

   // Number formats
   localparam int FRAC_BITS = 16;
   localparam int IQ        = 28;
   localparam int FW        = 18;
   localparam int RAD_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int NSTG      = RAD_W / 2;

   // Square scaling from Q.FRAC_BITS squared to Q.IQ
   localparam int SQ_SH  = 2 * FRAC_BITS - IQ;
   localparam int SQ_RSH = (SQ_SH > 0) ? SQ_SH : 0;
   localparam int SQ_LSH = (SQ_SH < 0) ? -SQ_SH : 0;
   localparam logic [RAD_W-1:0] SQ_HALF =
      (SQ_RSH > 0) ? (RAD_W'(1) << ((SQ_RSH > 0) ? SQ_RSH - 1 : 0)) : '0;
   localparam logic [30:0] SQ_MAX = 31'd1 << (IQ + 2);

   // Constant 3.0 in Q.IQ
   localparam logic signed [35:0] C3 = 36'sd3 <<< IQ;

   // Final scaling from 30 fraction bits down to FRAC_BITS
   localparam int FIN_SH = 30 - FRAC_BITS;
   localparam logic [ROOT_W:0] FIN_HALF =
      (FIN_SH > 0) ? ((ROOT_W+1)'(1) << ((FIN_SH > 0) ? FIN_SH - 1 : 0)) : '0;
   localparam logic [FW-1:0] MAG_MAX = 18'd131071;

   // Face codes
   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_NX = 3'd1;
   localparam logic [2:0] FACE_PY = 3'd2;
   localparam logic [2:0] FACE_NY = 3'd3;
   localparam logic [2:0] FACE_PZ = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   // Sideband that travels with each beat through the pipe
   typedef struct packed {
      logic [2:0]         face;
      logic               a_neg;
      logic               a_zero;
      logic               b_neg;
      logic               b_zero;
      logic signed [32:0] v0;
   } side_type;

endpackage
`default_nettype wire

### hdl/s2c_front.sv
// Front pipe: face pick, squares, root radicands (six stages).
`default_nettype none
module s2c_front import s2c_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_vld,
   input  wire logic signed [FW-1:0] vec_x,
   input  wire logic signed [FW-1:0] vec_y,
   input  wire logic signed [FW-1:0] vec_z,
   output logic                      rad_vld,
   output logic [RAD_W-1:0]          rad0,
   output logic [RAD_W-1:0]          rad1,
   output side_type                  side
);

   logic [5:0] vld_ff;

   logic [FW-1:0] ax, ay, az;
   side_type      s1_side_in, s1_side_ff;
   logic [FW-1:0] s1_am_in, s1_bm_in, s1_am_ff, s1_bm_ff;

   side_type        s2_side_ff;
   logic [2*FW-1:0] s2_asq_ff, s2_bsq_ff;

   logic [RAD_W-1:0] qa, qb;
   side_type         s3_side_ff;
   logic [30:0]      s3_a_in, s3_b_in, s3_a_ff, s3_b_ff;

   logic signed [35:0] a2, b2, d0, t0, t1;
   side_type           s4_side_in, s4_side_ff;
   logic [31:0]        s4_ta0_in, s4_ta1_in, s4_ta0_ff, s4_ta1_ff;
   logic [RAD_W-1:0]   s4_k0_in, s4_k1_in, s4_k0_ff, s4_k1_ff;

   side_type         s5_side_ff;
   logic [RAD_W-1:0] s5_p0_ff, s5_p1_ff, s5_k0_ff, s5_k1_ff;

   side_type         s6_side_ff;
   logic [RAD_W-1:0] s6_r0_ff, s6_r1_ff;

   // Advance valid bits with the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   // Stage 1: magnitudes and face pick
   always_comb begin
      ax = vec_x[FW-1] ? FW'(-vec_x) : FW'(vec_x);
      ay = vec_y[FW-1] ? FW'(-vec_y) : FW'(vec_y);
      az = vec_z[FW-1] ? FW'(-vec_z) : FW'(vec_z);
      s1_side_in    = '0;
      s1_side_in.b_neg = vec_y[FW-1];
      s1_side_in.b_zero = (vec_y == '0);
      s1_bm_in = ay;
      if (ax > ay && ax > az) begin
         s1_bm_in = az;
         s1_side_in.b_neg  = vec_z[FW-1];
         s1_side_in.b_zero = (vec_z == '0);
         s1_am_in = ay;
         s1_side_in.a_zero = (vec_y == '0);
         if (!vec_x[FW-1] && vec_x != '0) begin
            s1_side_in.face  = FACE_PX;
            s1_side_in.a_neg = vec_y[FW-1];
         end else begin
            s1_side_in.face  = FACE_NX;
            s1_side_in.a_neg = !vec_y[FW-1] && vec_y != '0;
         end
      end else if (ay > ax && ay > az) begin
         s1_bm_in = ax;
         s1_side_in.b_neg  = vec_x[FW-1];
         s1_side_in.b_zero = (vec_x == '0);
         s1_am_in = az;
         s1_side_in.a_zero = (vec_z == '0);
         if (!vec_y[FW-1] && vec_y != '0) begin
            s1_side_in.face  = FACE_PY;
            s1_side_in.a_neg = vec_z[FW-1];
         end else begin
            s1_side_in.face  = FACE_NY;
            s1_side_in.a_neg = !vec_z[FW-1] && vec_z != '0;
         end
      end else begin
         s1_am_in = ax;
         s1_side_in.a_zero = (vec_x == '0);
         if (!vec_z[FW-1] && vec_z != '0) begin
            s1_side_in.face  = FACE_PZ;
            s1_side_in.a_neg = vec_x[FW-1];
         end else begin
            s1_side_in.face  = FACE_NZ;
            s1_side_in.a_neg = !vec_x[FW-1] && vec_x != '0;
         end
      end
   end

   // Stage 3: scale squares to Q.IQ, saturate at 4.0
   always_comb begin
      qa = (({{(RAD_W-2*FW){1'b0}}, s2_asq_ff} + SQ_HALF) >> SQ_RSH) << SQ_LSH;
      qb = (({{(RAD_W-2*FW){1'b0}}, s2_bsq_ff} + SQ_HALF) >> SQ_RSH) << SQ_LSH;
      s3_a_in = (qa > {{(RAD_W-31){1'b0}}, SQ_MAX}) ? SQ_MAX : qa[30:0];
      s3_b_in = (qb > {{(RAD_W-31){1'b0}}, SQ_MAX}) ? SQ_MAX : qb[30:0];
   end

   // Stage 4: t terms, their magnitudes and 24*A, 24*B in Q.56
   always_comb begin
      a2 = $signed({4'd0, s3_a_ff, 1'b0});
      b2 = $signed({4'd0, s3_b_ff, 1'b0});
      d0 = a2 - b2;
      t0 = -d0 - C3;
      t1 = d0 - C3;
      s4_ta0_in = t0[35] ? 32'(-t0) : t0[31:0];
      s4_ta1_in = t1[35] ? 32'(-t1) : t1[31:0];
      s4_k0_in  = ({{(RAD_W-31){1'b0}}, s3_a_ff} << (IQ + 4))
                + ({{(RAD_W-31){1'b0}}, s3_a_ff} << (IQ + 3));
      s4_k1_in  = ({{(RAD_W-31){1'b0}}, s3_b_ff} << (IQ + 4))
                + ({{(RAD_W-31){1'b0}}, s3_b_ff} << (IQ + 3));
      s4_side_in    = s3_side_ff;
      s4_side_in.v0 = d0[32:0];
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_am_ff   <= s1_am_in;
         s1_bm_ff   <= s1_bm_in;

         s2_side_ff <= s1_side_ff;
         s2_asq_ff  <= {{FW{1'b0}}, s1_am_ff} * {{FW{1'b0}}, s1_bm_ff ^ s1_bm_ff | s1_am_ff};
         s2_bsq_ff  <= {{FW{1'b0}}, s1_bm_ff} * {{FW{1'b0}}, s1_bm_ff};

         s3_side_ff <= s2_side_ff;
         s3_a_ff    <= s3_a_in;
         s3_b_ff    <= s3_b_in;

         s4_side_ff <= s4_side_in;
         s4_ta0_ff  <= s4_ta0_in;
         s4_ta1_ff  <= s4_ta1_in;
         s4_k0_ff   <= s4_k0_in;
         s4_k1_ff   <= s4_k1_in;

         s5_side_ff <= s4_side_ff;
         s5_p0_ff   <= {32'd0, s4_ta0_ff} * {32'd0, s4_ta0_ff};
         s5_p1_ff   <= {32'd0, s4_ta1_ff} * {32'd0, s4_ta1_ff};
         s5_k0_ff   <= s4_k0_ff;
         s5_k1_ff   <= s4_k1_ff;

         s6_side_ff <= s5_side_ff;
         s6_r0_ff   <= (s5_p0_ff > s5_k0_ff) ? s5_p0_ff - s5_k0_ff : '0;
         s6_r1_ff   <= (s5_p1_ff > s5_k1_ff) ? s5_p1_ff - s5_k1_ff : '0;
      end
   end

   assign rad_vld = vld_ff[5];
   assign rad0    = s6_r0_ff;
   assign rad1    = s6_r1_ff;
   assign side    = s6_side_ff;

endmodule
`default_nettype wire

### hdl/s2c_isqrt.sv
// Dual-lane floor square root, one result bit per pipe stage.
`default_nettype none
module s2c_isqrt import s2c_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_vld,
   input  wire logic [RAD_W-1:0] rad0,
   input  wire logic [RAD_W-1:0] rad1,
   input  wire side_type         side_in,
   output logic                  res_vld,
   output logic [ROOT_W-1:0]     root0,
   output logic [ROOT_W-1:0]     root1,
   output logic [RAD_W-1:0]      rem0,
   output logic [RAD_W-1:0]      rem1,
   output side_type              side_out
);

   logic [NSTG-1:0]  vld_ff;
   side_type         side_ff [NSTG];
   logic [RAD_W-1:0] n_ff    [NSTG][2];
   logic [RAD_W-1:0] r_ff    [NSTG][2];
   logic [RAD_W-1:0] n_src   [NSTG][2];
   logic [RAD_W-1:0] r_src   [NSTG][2];
   logic [RAD_W-1:0] n_in    [NSTG][2];
   logic [RAD_W-1:0] r_in    [NSTG][2];
   logic [RAD_W:0]   trial   [NSTG][2];
   logic [RAD_W-1:0] bitv    [NSTG];

   // Stage sources: radicand at the head, previous stage after
   always_comb begin
      n_src[0][0] = rad0;
      n_src[0][1] = rad1;
      r_src[0][0] = '0;
      r_src[0][1] = '0;
      for (int s = 1; s < NSTG; s++) begin
         for (int l = 0; l < 2; l++) begin
            n_src[s][l] = n_ff[s-1][l];
            r_src[s][l] = r_ff[s-1][l];
         end
      end
   end

   // One trial subtract per stage and lane
   always_comb begin
      for (int s = 0; s < NSTG; s++) begin
         bitv[s] = RAD_W'(1) << (RAD_W - 2 - 2 * s);
         for (int l = 0; l < 2; l++) begin
            trial[s][l] = {1'b0, r_src[s][l]} + {1'b0, bitv[s]};
            if ({1'b0, n_src[s][l]} >= trial[s][l]) begin
               n_in[s][l] = n_src[s][l] - trial[s][l][RAD_W-1:0];
               r_in[s][l] = (r_src[s][l] >> 1) + bitv[s];
            end else begin
               n_in[s][l] = n_src[s][l];
               r_in[s][l] = r_src[s][l] >> 1;
            end
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_vld};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < NSTG; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < NSTG; s++) begin
            for (int l = 0; l < 2; l++) begin
               n_ff[s][l] <= n_in[s][l];
               r_ff[s][l] <= r_in[s][l];
            end
         end
      end
   end

   assign res_vld  = vld_ff[NSTG-1];
   assign root0    = r_ff[NSTG-1][0][ROOT_W-1:0];
   assign root1    = r_ff[NSTG-1][1][ROOT_W-1:0];
   assign rem0     = n_ff[NSTG-1][0];
   assign rem1     = n_ff[NSTG-1][1];
   assign side_out = side_ff[NSTG-1];

endmodule
`default_nettype wire

### hdl/s2c_mid.sv
// Middle pipe: nearest u terms, then W = max(3 - (u + v), 0) as radicands.
`default_nettype none
module s2c_mid import s2c_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire logic [ROOT_W-1:0] root0,
   input  wire logic [ROOT_W-1:0] root1,
   input  wire logic [RAD_W-1:0]  rem0,
   input  wire logic [RAD_W-1:0]  rem1,
   input  wire side_type          side_in,
   output logic                   rad_vld,
   output logic [RAD_W-1:0]       rad0,
   output logic [RAD_W-1:0]       rad1,
   output side_type               side_out
);

   logic [1:0]       vld_ff;
   side_type         sa_side_ff, sb_side_ff;
   logic [ROOT_W:0]  u0_in, u1_in, u0_ff, u1_ff;
   logic signed [35:0] v0x, uv_u, uv_v, w_u, w_v;
   logic [RAD_W-1:0] x_u_in, x_v_in, x_u_ff, x_v_ff;

   // Nearest root: bump when the remainder exceeds the floor root
   always_comb begin
      u0_in = {1'b0, root0} + (ROOT_W+1)'(rem0 > {{(RAD_W-ROOT_W){1'b0}}, root0});
      u1_in = {1'b0, root1} + (ROOT_W+1)'(rem1 > {{(RAD_W-ROOT_W){1'b0}}, root1});
   end

   // face_u takes u1 + v1 with v1 = -v0, face_v takes u0 + v0
   always_comb begin
      v0x    = {{3{sa_side_ff.v0[32]}}, sa_side_ff.v0};
      uv_u   = $signed({3'd0, u1_ff}) - v0x;
      uv_v   = $signed({3'd0, u0_ff}) + v0x;
      w_u    = C3 - uv_u;
      w_v    = C3 - uv_v;
      x_u_in = w_u[35] ? '0 : {w_u[32:0], 31'd0};
      x_v_in = w_v[35] ? '0 : {w_v[32:0], 31'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_side_ff <= side_in;
         u0_ff      <= u0_in;
         u1_ff      <= u1_in;
         sb_side_ff <= sa_side_ff;
         x_u_ff     <= x_u_in;
         x_v_ff     <= x_v_in;
      end
   end

   assign rad_vld  = vld_ff[1];
   assign rad0     = x_u_ff;
   assign rad1     = x_v_ff;
   assign side_out = sb_side_ff;

endmodule
`default_nettype wire

### hdl/s2c_tail.sv
// Result register: scale magnitudes, saturate, restore signs, hold the beat.
`default_nettype none
module s2c_tail import s2c_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_vld,
   input  wire logic [ROOT_W-1:0] root0,
   input  wire logic [ROOT_W-1:0] root1,
   input  wire logic [RAD_W-1:0]  rem0,
   input  wire logic [RAD_W-1:0]  rem1,
   input  wire side_type          side_in,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic [39:0]            rsp_tdata
);

   logic          load;
   logic          vld_ff;
   logic [39:0]   data_in, data_ff;
   logic [FW-1:0] cu, cv;

   // Scale a 30-fraction-bit root to FRAC_BITS and apply the sign
   function automatic logic [FW-1:0] coord(input logic [ROOT_W-1:0] r,
                                           input logic [RAD_W-1:0]  rm,
                                           input logic              neg,
                                           input logic              zero);
      logic [ROOT_W:0] m;
      logic [FW-1:0]   s;
      if (FIN_SH == 0) begin
         m = {1'b0, r} + (ROOT_W+1)'(rm > {{(RAD_W-ROOT_W){1'b0}}, r});
      end else begin
         m = ({1'b0, r} + FIN_HALF) >> FIN_SH;
      end
      s = (m > (ROOT_W+1)'(MAG_MAX)) ? MAG_MAX : m[FW-1:0];
      if (zero) begin
         return '0;
      end else if (neg) begin
         return FW'(-s);
      end
      return s;
   endfunction

   always_comb begin
      load    = !vld_ff || rsp_tready;
      cu      = coord(root0, rem0, side_in.a_neg, side_in.a_zero);
      cv      = coord(root1, rem1, side_in.b_neg, side_in.b_zero);
      data_in = {1'b0, cv, cu, side_in.face};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire

### hdl/sphere_to_cube_face_map_top.sv
// Top level: maps a unit vector to a cube face and two face coordinates.
// Beats pass front pipe, root pipe, middle pipe, root pipe and result register in order.
// One beat per cycle when not stalled; two 32-stage root pipes set the depth, not the rate.
// Backpressure stalls the whole pipe only when its last stage and the result register
// are both full; bubbles ahead of the result register are filled meanwhile.
// Reset (synchronous, active high) clears all valid bits; no clearing pass is needed.
`default_nettype none
module sphere_to_cube_face_map_top import s2c_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // vec_x[17:0], vec_y[35:18], vec_z[53:36], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // face[2:0], face_u[20:3], face_v[38:21], zero pad
);

   logic             en;
   logic             f_vld, q1_vld, m_vld, q2_vld;
   logic [RAD_W-1:0] f_rad0, f_rad1, m_rad0, m_rad1;
   logic [ROOT_W-1:0] q1_root0, q1_root1, q2_root0, q2_root1;
   logic [RAD_W-1:0] q1_rem0, q1_rem1, q2_rem0, q2_rem1;
   side_type         f_side, q1_side, m_side, q2_side;

   // Stall only when the last stage and the result register are both occupied
   assign en         = !q2_vld || !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   s2c_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .vec_x   ($signed(req_tdata[17:0])),
      .vec_y   ($signed(req_tdata[35:18])),
      .vec_z   ($signed(req_tdata[53:36])),
      .rad_vld (f_vld),
      .rad0    (f_rad0),
      .rad1    (f_rad1),
      .side    (f_side)
   );

   s2c_isqrt u_root_uv (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (f_vld),
      .rad0     (f_rad0),
      .rad1     (f_rad1),
      .side_in  (f_side),
      .res_vld  (q1_vld),
      .root0    (q1_root0),
      .root1    (q1_root1),
      .rem0     (q1_rem0),
      .rem1     (q1_rem1),
      .side_out (q1_side)
   );

   s2c_mid u_mid (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (q1_vld),
      .root0    (q1_root0),
      .root1    (q1_root1),
      .rem0     (q1_rem0),
      .rem1     (q1_rem1),
      .side_in  (q1_side),
      .rad_vld  (m_vld),
      .rad0     (m_rad0),
      .rad1     (m_rad1),
      .side_out (m_side)
   );

   s2c_isqrt u_root_mag (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m_vld),
      .rad0     (m_rad0),
      .rad1     (m_rad1),
      .side_in  (m_side),
      .res_vld  (q2_vld),
      .root0    (q2_root0),
      .root1    (q2_root1),
      .rem0     (q2_rem0),
      .rem1     (q2_rem1),
      .side_out (q2_side)
   );

   s2c_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (q2_vld),
      .root0      (q2_root0),
      .root1      (q2_root1),
      .rem0       (q2_rem0),
      .rem1       (q2_rem1),
      .side_in    (q2_side),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### hdl/s2c_check.sv
// Port-level checker for the face mapper, bound to the top level.
`default_nettype none
module s2c_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A stalled result beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // Face code stays within the six faces
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7)
      else $error("face code out of range");

   // Saturated magnitudes never reach the most negative code
   a_coord_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:3] != 18'h20000 && rsp_tdata[38:21] != 18'h20000)
      else $error("coordinate magnitude not saturated");

   // The input side is never blocked while the result register is free
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with an empty result register");

endmodule

bind sphere_to_cube_face_map_top s2c_check u_s2c_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
